/* hw/rtl/rbox_pkg.sv */
package rbox_pkg;

   localparam int FRAC_BITS = 16;
   localparam int NUM_W = 34;
   localparam int DIV_STEPS = NUM_W + FRAC_BITS;
   localparam int REM_W = 34;
   localparam int QUO_W = DIV_STEPS;
   localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic signed [31:0] t_near;
      logic signed [31:0] t_far;
   } rsp_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic [NUM_W-1:0] num;
      logic [31:0]      dmag;
      logic             neg;
      logic             par;
      logic signed [31:0] ptval;
   } lane_type;

   typedef struct packed {
      lane_type [1:0] lane;
   } axis_type;

   typedef struct packed {
      logic              valid;
      axis_type [2:0]    axis;
   } slice_type;

endpackage

/* hw/rtl/rbox_cell.sv */
module rbox_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  rbox_pkg::slice_type  slice_in,
   output rbox_pkg::slice_type  slice_out
);

   rbox_pkg::slice_type slice_ff;
   rbox_pkg::slice_type slice_in_w;

   function automatic rbox_pkg::lane_type step_lane(input rbox_pkg::lane_type l);
      rbox_pkg::lane_type r;
      logic [rbox_pkg::REM_W:0] trial;
      logic [rbox_pkg::REM_W-1:0] shifted;
      r = l;
      shifted = {l.rem[rbox_pkg::REM_W-2:0], l.num[rbox_pkg::NUM_W-1]};
      r.num = {l.num[rbox_pkg::NUM_W-2:0], 1'b0};
      trial = {1'b0, shifted} - {3'b000, l.dmag};
      if (!trial[rbox_pkg::REM_W]) begin
         r.rem = trial[rbox_pkg::REM_W-1:0];
         r.quo = {l.quo[rbox_pkg::QUO_W-2:0], 1'b1};
      end else begin
         r.rem = shifted;
         r.quo = {l.quo[rbox_pkg::QUO_W-2:0], 1'b0};
      end
      return r;
   endfunction

   always_comb begin
      slice_in_w = slice_in;
      for (int a = 0; a < 3; a++) begin
         for (int k = 0; k < 2; k++) begin
            slice_in_w.axis[a].lane[k] = step_lane(slice_in.axis[a].lane[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_ff.valid <= 1'b0;
      end else if (advance) begin
         slice_ff.valid <= slice_in_w.valid;
      end
      if (advance) begin
         slice_ff.axis <= slice_in_w.axis;
      end
   end

   assign slice_out = slice_ff;

endmodule

/* hw/rtl/ray_unit_box_slab_intersect_core.sv */
// Ray against the cube spanning -1..1 per axis, slab test, Q16.16.
// Request channel req_valid/req_ready/req_data carries origin and
// direction; response channel rsp_valid/rsp_ready/rsp_data carries hit,
// t_near and t_far. csr_valid/csr_ready/csr_data writes parallel_epsilon
// (reset 7); write it only while the block is idle.
// Six restoring dividers run as a chain of 50 cells, one quotient bit per
// cell, all six lanes stepping together. From request to response a ray
// passes the setup register, 50 divide cells and the output register;
// the resolve logic is combinational ahead of the output register.
// One request is accepted per cycle while req_ready is high.
// Reset clears all valid bits; in-flight requests are dropped.
// When the receiver stalls the whole chain holds; req_ready falls only
// when the output register is full and not being taken.
module ray_unit_box_slab_intersect_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rbox_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rbox_pkg::rsp_type   rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [15:0]         csr_data
);

   localparam int N = rbox_pkg::DIV_STEPS;

   logic [15:0] eps_ff;
   logic        advance;
   rbox_pkg::slice_type chain [0:N];
   rbox_pkg::slice_type head_ff, head_in;
   rbox_pkg::rsp_type   out_ff, out_in;
   logic                out_vld_ff;

   assign advance = !out_vld_ff || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= 16'd7;
      end else if (csr_valid) begin
         eps_ff <= csr_data;
      end
   end

   function automatic rbox_pkg::lane_type setup_lane(
      input logic signed [rbox_pkg::NUM_W-1:0] n,
      input logic signed [31:0] d,
      input logic par,
      input logic first);
      rbox_pkg::lane_type l;
      logic [rbox_pkg::NUM_W-1:0] nmag;
      nmag = n[rbox_pkg::NUM_W-1] ? rbox_pkg::NUM_W'(-n) : rbox_pkg::NUM_W'(n);
      l.rem = '0;
      l.quo = '0;
      l.num = nmag;
      l.dmag = d[31] ? 32'(-d) : 32'(d);
      l.neg = n[rbox_pkg::NUM_W-1] ^ d[31];
      l.par = par;
      if (n == '0) begin
         l.ptval = first ? rbox_pkg::SAT_MIN : rbox_pkg::SAT_MAX;
      end else begin
         l.ptval = n[rbox_pkg::NUM_W-1] ? rbox_pkg::SAT_MIN : rbox_pkg::SAT_MAX;
      end
      return l;
   endfunction

   always_comb begin
      logic signed [31:0] o, d;
      logic signed [rbox_pkg::NUM_W-1:0] one, n0, n1;
      logic [32:0] mag;
      logic par;
      rbox_pkg::axis_type [2:0] ax;
      one = rbox_pkg::NUM_W'(1) <<< rbox_pkg::FRAC_BITS;
      for (int a = 0; a < 3; a++) begin
         case (a)
            0: begin o = req_data.origin_x; d = req_data.dir_x; end
            1: begin o = req_data.origin_y; d = req_data.dir_y; end
            default: begin o = req_data.origin_z; d = req_data.dir_z; end
         endcase
         n0 = -one - rbox_pkg::NUM_W'(o);
         n1 = one - rbox_pkg::NUM_W'(o);
         mag = d[31] ? 33'(-{d[31], d}) : {1'b0, d};
         par = (d == 0) || (mag < {17'd0, eps_ff});
         ax[a].lane[0] = setup_lane(n0, d, par, 1'b1);
         ax[a].lane[1] = setup_lane(n1, d, par, 1'b0);
      end
      head_in.valid = req_valid;
      head_in.axis = ax;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (advance) begin
         head_ff.valid <= head_in.valid;
      end
      if (advance) begin
         head_ff.axis <= head_in.axis;
      end
   end

   assign chain[0] = head_ff;

   for (genvar i = 0; i < N; i++) begin : g_cell
      rbox_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .slice_in  (chain[i]),
         .slice_out (chain[i+1])
      );
   end

   function automatic logic signed [31:0] finish_lane(input rbox_pkg::lane_type l);
      logic signed [rbox_pkg::QUO_W:0] q;
      if (l.par) begin
         return l.ptval;
      end
      q = l.neg ? -$signed({1'b0, l.quo}) : $signed({1'b0, l.quo});
      if (q > $signed((rbox_pkg::QUO_W+1)'(rbox_pkg::SAT_MAX))) begin
         return rbox_pkg::SAT_MAX;
      end
      if (q < $signed({{(rbox_pkg::QUO_W-31){1'b1}}, 32'h80000000})) begin
         return rbox_pkg::SAT_MIN;
      end
      return q[31:0];
   endfunction

   always_comb begin
      logic signed [31:0] t0, t1, lo, hi, tn, tf;
      tn = rbox_pkg::SAT_MIN;
      tf = rbox_pkg::SAT_MAX;
      for (int a = 0; a < 3; a++) begin
         t0 = finish_lane(chain[N].axis[a].lane[0]);
         t1 = finish_lane(chain[N].axis[a].lane[1]);
         lo = (t0 > t1) ? t1 : t0;
         hi = (t0 > t1) ? t0 : t1;
         if (a == 0 || lo > tn) tn = lo;
         if (a == 0 || hi < tf) tf = hi;
      end
      out_in.hit = (tn <= tf);
      out_in.t_near = tn;
      out_in.t_far = tf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= chain[N].valid;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data = out_ff;

endmodule

/* hw/rtl/rbox_checker.sv */
module rbox_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rbox_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   a_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.hit == (rsp_data.t_near <= rsp_data.t_far))
      else $error("hit flag disagrees with distances");

endmodule

bind ray_unit_box_slab_intersect_core rbox_checker u_rbox_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* tb/slab_checker.sv */
`timescale 1ns / 1ps

module slab_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  rbox_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  rbox_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [15:0]       csr_data,
   output int                errors,
   output int                pending
);

   localparam longint ONE = longint'(1) << rbox_pkg::FRAC_BITS;
   localparam longint TMAX = 64'sd2147483647;
   localparam longint TMIN = -64'sd2147483648;

   logic [15:0]       epsilon;
   rbox_pkg::rsp_type hits_q[$];

   function automatic longint clamp32(input longint v);
      if (v > TMAX) return TMAX;
      if (v < TMIN) return TMIN;
      return v;
   endfunction

   // ordered entry/exit distances for one slab
   function automatic void slab_span(input logic signed [31:0] o, input logic signed [31:0] d,
                                     input logic [15:0] eps, output longint lo,
                                     output longint hi);
      longint n0, n1, dd, mag, t0, t1;
      n0 = -ONE - longint'(o);
      n1 = ONE - longint'(o);
      dd = longint'(d);
      mag = dd < 0 ? -dd : dd;
      if (dd == 0 || mag < longint'(eps)) begin
         t0 = n0 > 0 ? TMAX : TMIN;
         t1 = n1 < 0 ? TMIN : TMAX;
      end else begin
         t0 = clamp32((n0 * ONE) / dd);
         t1 = clamp32((n1 * ONE) / dd);
      end
      if (t0 > t1) begin
         lo = t1;
         hi = t0;
      end else begin
         lo = t0;
         hi = t1;
      end
   endfunction

   function automatic rbox_pkg::rsp_type box_hit(input rbox_pkg::req_type r,
                                                 input logic [15:0] eps);
      longint lo[3], hi[3], tn, tf;
      rbox_pkg::rsp_type p;
      slab_span(r.origin_x, r.dir_x, eps, lo[0], hi[0]);
      slab_span(r.origin_y, r.dir_y, eps, lo[1], hi[1]);
      slab_span(r.origin_z, r.dir_z, eps, lo[2], hi[2]);
      tn = lo[0];
      tf = hi[0];
      for (int a = 1; a < 3; a++) begin
         if (lo[a] > tn) tn = lo[a];
         if (hi[a] < tf) tf = hi[a];
      end
      p.hit = tn <= tf;
      p.t_near = tn[31:0];
      p.t_far = tf[31:0];
      return p;
   endfunction

   assign pending = hits_q.size();

   always @(posedge clock) begin
      rbox_pkg::rsp_type want;
      if (reset) begin
         epsilon <= 16'd7;
         hits_q.delete();
      end else begin
         if (csr_valid && csr_ready) epsilon <= csr_data;
         if (req_valid && req_ready) hits_q.push_back(box_hit(req_data, epsilon));
         if (rsp_valid && rsp_ready) begin
            if (hits_q.size() == 0) begin
               errors <= errors + 1;
               if (errors < 10) $display("unexpected response %p", rsp_data);
            end else begin
               want = hits_q.pop_front();
               if (want.hit !== rsp_data.hit || want.t_near !== rsp_data.t_near ||
                   want.t_far !== rsp_data.t_far) begin
                  errors <= errors + 1;
                  if (errors < 10)
                     $display("mismatch exp %0d/%0d/%0d got %0d/%0d/%0d",
                              want.hit, want.t_near, want.t_far,
                              rsp_data.hit, rsp_data.t_near, rsp_data.t_far);
               end
            end
         end
      end
   end

   initial errors = 0;
endmodule

/* tb/ray_unit_box_slab_intersect_core_tb.sv */
`timescale 1ns / 1ps

module ray_unit_box_slab_intersect_core_tb;

   localparam int LIMIT = 600000;
   localparam int DRAIN = 60;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   rbox_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rbox_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [15:0]       csr_data;
   int                errors;
   int                pending;
   int                send_idle;
   int                recv_idle;
   int                cycles;
   logic [15:0]       cur_eps;

   ray_unit_box_slab_intersect_core uut (.*);

   slab_checker chk (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle);

   task automatic send_ray(input rbox_pkg::req_type r);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic ray6(input int ox, input int oy, input int oz, input int dx, input int dy,
                       input int dz);
      rbox_pkg::req_type r;
      r.origin_x = ox;
      r.origin_y = oy;
      r.origin_z = oz;
      r.dir_x = dx;
      r.dir_y = dy;
      r.dir_z = dz;
      send_ray(r);
   endtask

   task automatic set_epsilon(input logic [15:0] v);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_eps = v;
   endtask

   function automatic logic [31:0] rand_origin();
      int k;
      k = $urandom_range(9);
      if (k < 5) return $signed($urandom_range(0, 6 * 65536)) - 3 * 65536;
      if (k < 7) return $urandom;
      case ($urandom_range(5))
         0: return 32'sd65536;
         1: return -32'sd65536;
         2: return 32'd0;
         3: return 32'h80000000;
         4: return 32'h7fffffff;
         default: return $signed($urandom_range(0, 4)) + 65534;
      endcase
   endfunction

   function automatic logic [31:0] rand_dir();
      int k;
      logic [31:0] m;
      k = $urandom_range(9);
      if (k < 4) m = $urandom_range(0, 4 * 65536);
      else if (k < 6) return $urandom;
      else if (k < 8) m = $urandom_range(0, int'(cur_eps) + 1);
      else if (k == 8) m = $urandom_range(0, 2);
      else m = $urandom_range(0, 64);
      return $urandom_range(1) ? -m : m;
   endfunction

   task automatic random_rays(input int n);
      for (int i = 0; i < n; i++)
         ray6(rand_origin(), rand_origin(), rand_origin(), rand_dir(), rand_dir(), rand_dir());
   endtask

   initial begin
      int eps_list[6];
      eps_list = '{7, 0, 65535, 1, 300, 0};
      eps_list[5] = $urandom_range(0, 65535);
      reset = 1;
      req_valid = 0;
      req_data = '0;
      rsp_ready = 0;
      csr_valid = 0;
      csr_data = '0;
      cycles = 0;
      cur_eps = 7;
      send_idle = 36;
      recv_idle = 47;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset epsilon, axis rays, parallel, extremes
      ray6(0, 0, 0, 65536, 0, 0);
      ray6(-3 * 65536, 0, 0, 65536, 0, 0);
      ray6(3 * 65536, 0, 0, 65536, 65536, 65536);
      ray6(0, 0, 0, 0, 0, 0);
      ray6(-65536, 0, 0, 0, 65536, 0);
      ray6(65536, 65536, -65536, 0, 0, 0);
      ray6(2 * 65536, 0, 0, 0, 0, 65536);
      ray6(0, 0, 0, 6, -6, 7);
      ray6(0, 0, 0, -7, 7, -8);
      ray6(32'h7fffffff, 32'h80000000, 0, 1, -1, 65536);
      ray6(32'h80000000, 32'h7fffffff, 32'h80000000,
           32'h7fffffff, 32'h80000000, 32'h80000000);
      ray6(0, 0, 0, 1 <<< 8, 1 <<< 8, 1 <<< 8);
      ray6(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      ray6(-32'sd32768, 32'sd32768, 0, 32'sd65536, -32'sd65536, 32'sd100);
      ray6(65535, -65537, 65537, 8, -9, 65535);

      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 2) begin
            send_idle = 47;
            recv_idle = 36;
         end
         if (ph == 4) begin
            send_idle = 0;
            recv_idle = 0;
         end
         set_epsilon(16'(eps_list[ph]));
         if (ph == 1) begin
            ray6(0, 0, 0, 0, 0, 0);
            ray6(65536, 0, -65536, 0, 1, 0);
         end
         random_rays(256);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
